### src/qvr_pkg.sv
// qvr_pkg: widths and shared types for the quaternion vector rotation core
// used by qvr_div_pipe and quaternion_vector_rotation_core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qvr_pkg;

    localparam int COMP_W   = 16;   // input component width
    localparam int PROD_W   = 32;   // 16 x 16 signed product
    localparam int NORM_W   = 33;   // |q|^2, unsigned
    localparam int MAT_W    = 35;   // rotation numerator entry, signed
    localparam int TERM_W   = MAT_W + COMP_W;  // matrix entry times component
    localparam int SUM_W    = TERM_W + 2;      // sum of three terms
    localparam int DEN_W    = NORM_W + 1;      // 2 * |q|^2
    localparam int QUOT_W   = 17;              // quotient magnitude bits
    localparam int DIV_W    = DEN_W + QUOT_W - 1;  // dividend 2|num| + n
    localparam int OUT_W    = 17;
    localparam int AXIS_IN_W  = 7 * COMP_W;
    localparam int AXIS_OUT_W = 56;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 17'sd65535;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -17'sd65536;

    typedef struct packed {
        logic neg;
        logic zero;
    } div_tag_t;

endpackage

`default_nettype wire

### src/qvr_div_pipe.sv
// qvr_div_pipe: restoring divider, one quotient bit per pipeline stage
// depends on qvr_pkg
`timescale 1ns / 1ps
`default_nettype none

module qvr_div_pipe (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire logic                        valid_i,
    input  wire logic [qvr_pkg::DIV_W-1:0]   num_i,
    input  wire logic [qvr_pkg::DEN_W-1:0]   den_i,
    input  wire qvr_pkg::div_tag_t           tag_i,
    output logic                             valid_o,
    output logic [qvr_pkg::QUOT_W-1:0]       quot_o,
    output qvr_pkg::div_tag_t                tag_o
);

    localparam int NS = qvr_pkg::QUOT_W;

    logic [qvr_pkg::DIV_W-1:0]  rem_src  [NS];
    logic [qvr_pkg::DEN_W-1:0]  den_src  [NS];
    logic [qvr_pkg::QUOT_W-1:0] quot_src [NS];
    qvr_pkg::div_tag_t          tag_src  [NS];
    logic                       vld_src  [NS];

    logic [qvr_pkg::DIV_W-1:0]  rem_reg  [NS];
    logic [qvr_pkg::DEN_W-1:0]  den_reg  [NS];
    logic [qvr_pkg::QUOT_W-1:0] quot_reg [NS];
    qvr_pkg::div_tag_t          tag_reg  [NS];
    logic                       vld_reg  [NS];

    genvar i;
    generate
        for (i = 0; i < NS; i++) begin : g_stage
            localparam int SH = NS - 1 - i;
            logic [qvr_pkg::DIV_W-1:0] sub;
            logic                      ge;

            if (i == 0) begin : g_first
                assign rem_src[i]  = num_i;
                assign den_src[i]  = den_i;
                assign quot_src[i] = '0;
                assign tag_src[i]  = tag_i;
                assign vld_src[i]  = valid_i;
            end else begin : g_next
                assign rem_src[i]  = rem_reg[i-1];
                assign den_src[i]  = den_reg[i-1];
                assign quot_src[i] = quot_reg[i-1];
                assign tag_src[i]  = tag_reg[i-1];
                assign vld_src[i]  = vld_reg[i-1];
            end

            assign sub = qvr_pkg::DIV_W'(den_src[i]) << SH;
            assign ge  = (rem_src[i] >= sub);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[i] <= 1'b0;
                end else if (en) begin
                    vld_reg[i] <= vld_src[i];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i]  <= ge ? (rem_src[i] - sub) : rem_src[i];
                    den_reg[i]  <= den_src[i];
                    quot_reg[i] <= {quot_src[i][qvr_pkg::QUOT_W-2:0], ge};
                    tag_reg[i]  <= tag_src[i];
                end
            end
        end
    endgenerate

    assign valid_o = vld_reg[NS-1];
    assign quot_o  = quot_reg[NS-1];
    assign tag_o   = tag_reg[NS-1];

endmodule

`default_nettype wire

### src/quaternion_vector_rotation_core.sv
// quaternion_vector_rotation_core: rotates a vector by q v q* / |q|^2
// depends on qvr_pkg and qvr_div_pipe
//
// channel  dir  tdata (low bit up)                               tuser
// s_axis   in   quat_w quat_x quat_y quat_z vec_x vec_y vec_z      -
// m_axis   out  rot_x rot_y rot_z, zero padded to 56 bits          zero_quat
//
// one word per cycle while the output is not held; 5 arithmetic stages, 17 divider
// stages (one quotient bit per stage) and one output stage
// the whole pipeline holds while the output word waits, so no word is lost
// synchronous active-low reset clears the valid bits only
`timescale 1ns / 1ps
`default_nettype none

module quaternion_vector_rotation_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z
    input  wire logic [qvr_pkg::AXIS_IN_W-1:0]     s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // rot_x, rot_y, rot_z, zeros
    output logic [qvr_pkg::AXIS_OUT_W-1:0]         m_axis_tdata,
    // zero_quat
    output logic                                   m_axis_tuser
);

    localparam int CW = qvr_pkg::COMP_W;
    localparam int PW = qvr_pkg::PROD_W;
    localparam int MW = qvr_pkg::MAT_W;
    localparam int TW = qvr_pkg::TERM_W;
    localparam int SW = qvr_pkg::SUM_W;
    localparam int OW = qvr_pkg::OUT_W;

    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // input fields
    logic signed [CW-1:0] qw, qx, qy, qz;
    logic signed [CW-1:0] vin [3];
    assign qw     = s_axis_tdata[0*CW +: CW];
    assign qx     = s_axis_tdata[1*CW +: CW];
    assign qy     = s_axis_tdata[2*CW +: CW];
    assign qz     = s_axis_tdata[3*CW +: CW];
    assign vin[0] = s_axis_tdata[4*CW +: CW];
    assign vin[1] = s_axis_tdata[5*CW +: CW];
    assign vin[2] = s_axis_tdata[6*CW +: CW];

    // stage 1: quaternion products
    logic                 v1_reg;
    logic signed [PW-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PW-1:0] xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    logic signed [CW-1:0] vec1_reg [3];

    // stage 2: norm and rotation numerator
    logic                          v2_reg;
    logic [qvr_pkg::NORM_W-1:0]    n2_reg;
    logic signed [MW-1:0]          r_reg [9];
    logic signed [CW-1:0]          vec2_reg [3];

    // stage 3: matrix times vector terms
    logic                          v3_reg;
    logic [qvr_pkg::NORM_W-1:0]    n3_reg;
    logic signed [TW-1:0]          t_reg [9];

    // stage 4: row sums
    logic                          v4_reg;
    logic [qvr_pkg::NORM_W-1:0]    n4_reg;
    logic signed [SW-1:0]          s_reg [3];

    // stage 5: divider operands
    logic                          v5_reg;
    logic [qvr_pkg::DIV_W-1:0]     num_reg [3];
    logic [qvr_pkg::DEN_W-1:0]     den_reg;
    qvr_pkg::div_tag_t             tag5_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    logic signed [MW-1:0] sq_w, sq_x, sq_y, sq_z;
    logic signed [MW-1:0] n_full;
    assign sq_w   = MW'(ww_reg);
    assign sq_x   = MW'(xx_reg);
    assign sq_y   = MW'(yy_reg);
    assign sq_z   = MW'(zz_reg);
    assign n_full = sq_w + sq_x + sq_y + sq_z;

    always_ff @(posedge aclk) begin
        if (en) begin
            ww_reg <= qw * qw;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            zz_reg <= qz * qz;
            xy_reg <= qx * qy;
            wz_reg <= qw * qz;
            xz_reg <= qx * qz;
            wy_reg <= qw * qy;
            yz_reg <= qy * qz;
            wx_reg <= qw * qx;
            for (int k = 0; k < 3; k++) begin
                vec1_reg[k] <= vin[k];
            end

            n2_reg   <= n_full[qvr_pkg::NORM_W-1:0];
            r_reg[0] <= sq_w + sq_x - sq_y - sq_z;
            r_reg[1] <= (MW'(xy_reg) - MW'(wz_reg)) <<< 1;
            r_reg[2] <= (MW'(xz_reg) + MW'(wy_reg)) <<< 1;
            r_reg[3] <= (MW'(xy_reg) + MW'(wz_reg)) <<< 1;
            r_reg[4] <= sq_w - sq_x + sq_y - sq_z;
            r_reg[5] <= (MW'(yz_reg) - MW'(wx_reg)) <<< 1;
            r_reg[6] <= (MW'(xz_reg) - MW'(wy_reg)) <<< 1;
            r_reg[7] <= (MW'(yz_reg) + MW'(wx_reg)) <<< 1;
            r_reg[8] <= sq_w - sq_x - sq_y + sq_z;
            for (int k = 0; k < 3; k++) begin
                vec2_reg[k] <= vec1_reg[k];
            end

            n3_reg <= n2_reg;
            for (int k = 0; k < 9; k++) begin
                t_reg[k] <= TW'(r_reg[k]) * TW'(vec2_reg[k % 3]);
            end

            n4_reg <= n3_reg;
            for (int k = 0; k < 3; k++) begin
                s_reg[k] <= SW'(t_reg[3*k]) + SW'(t_reg[3*k+1]) + SW'(t_reg[3*k+2]);
            end
        end
    end

    // stage 5: |sum| * 2 + n over 2n gives the rounded magnitude
    logic [SW-1:0] mag [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag[k] = s_reg[k][SW-1] ? SW'(-s_reg[k]) : SW'(s_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg <= {n4_reg, 1'b0};
            for (int k = 0; k < 3; k++) begin
                num_reg[k] <= qvr_pkg::DIV_W'({mag[k][SW-2:0], 1'b0})
                            + qvr_pkg::DIV_W'(n4_reg);
                tag5_reg[k].neg  <= s_reg[k][SW-1];
                tag5_reg[k].zero <= (n4_reg == '0);
            end
        end
    end

    logic                        dv    [3];
    logic [qvr_pkg::QUOT_W-1:0]  quot  [3];
    qvr_pkg::div_tag_t           dtag  [3];

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_div
            qvr_div_pipe u_div (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (en),
                .valid_i (v5_reg),
                .num_i   (num_reg[g]),
                .den_i   (den_reg),
                .tag_i   (tag5_reg[g]),
                .valid_o (dv[g]),
                .quot_o  (quot[g]),
                .tag_o   (dtag[g])
            );
        end
    endgenerate

    // sign and clamp
    logic signed [OW-1:0] rot_next [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (dtag[k].zero) begin
                rot_next[k] = '0;
            end else if (dtag[k].neg) begin
                rot_next[k] = (quot[k] > 17'd65536) ? qvr_pkg::OUT_MIN : OW'(-quot[k]);
            end else begin
                rot_next[k] = (quot[k] > 17'd65535) ? qvr_pkg::OUT_MAX : OW'(quot[k]);
            end
        end
    end

    logic                 out_vld_reg;
    logic signed [OW-1:0] rot_reg [3];
    logic                 zero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= dv[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                rot_reg[k] <= rot_next[k];
            end
            zero_reg <= dtag[0].zero;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {5'd0, rot_reg[2], rot_reg[1], rot_reg[0]};
    assign m_axis_tuser  = zero_reg;

    // zero quaternion gives a zero vector
    a_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("zero quaternion word with nonzero vector");

    // a rotation keeps length, so no component passes |v| max
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (rot_reg[0] <= 17'sd56756 && rot_reg[0] >= -17'sd56756
                        && rot_reg[1] <= 17'sd56756 && rot_reg[1] >= -17'sd56756
                        && rot_reg[2] <= 17'sd56756 && rot_reg[2] >= -17'sd56756))
        else $error("rotated component beyond input length");

    // the three dividers run in lockstep; tags only matter on valid words
    a_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv[0] == dv[1]) && (dv[1] == dv[2])
        && (!dv[0] || (dtag[0].zero == dtag[2].zero)))
        else $error("divider lanes out of step");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

### test/testbench.sv
// testbench for quaternion_vector_rotation_core: random and directed quaternion/vector
// words, rotation predicted in 64-bit integer arithmetic; depends on qvr_pkg and the core
`timescale 1ns / 1ps

class rotation_scoreboard;
    logic [16:0] exp_x[$];
    logic [16:0] exp_y[$];
    logic [16:0] exp_z[$];
    logic        exp_zero[$];
    int          mismatches;
    int          checked;
    int          zero_seen;

    function new();
        mismatches = 0;
        checked = 0;
        zero_seen = 0;
    endfunction

    // round num/den to nearest, ties away from zero, then clamp to 17 bits
    function logic [16:0] round_sat(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        if (num < 0) q = -q;
        if (q > 65535) q = 65535;
        if (q < -65536) q = -65536;
        return q[16:0];
    endfunction

    function void note_input(logic [111:0] word);
        longint w, x, y, z, vx, vy, vz, n;
        longint r00, r01, r02, r10, r11, r12, r20, r21, r22;
        w  = longint'($signed(word[15:0]));
        x  = longint'($signed(word[31:16]));
        y  = longint'($signed(word[47:32]));
        z  = longint'($signed(word[63:48]));
        vx = longint'($signed(word[79:64]));
        vy = longint'($signed(word[95:80]));
        vz = longint'($signed(word[111:96]));
        n = w*w + x*x + y*y + z*z;
        if (n == 0) begin
            exp_x.push_back('0);
            exp_y.push_back('0);
            exp_z.push_back('0);
            exp_zero.push_back(1'b1);
            return;
        end
        r00 = w*w + x*x - y*y - z*z;
        r01 = 2 * (x*y - w*z);
        r02 = 2 * (x*z + w*y);
        r10 = 2 * (x*y + w*z);
        r11 = w*w - x*x + y*y - z*z;
        r12 = 2 * (y*z - w*x);
        r20 = 2 * (x*z - w*y);
        r21 = 2 * (y*z + w*x);
        r22 = w*w - x*x - y*y + z*z;
        exp_x.push_back(round_sat(r00*vx + r01*vy + r02*vz, n));
        exp_y.push_back(round_sat(r10*vx + r11*vy + r12*vz, n));
        exp_z.push_back(round_sat(r20*vx + r21*vy + r22*vz, n));
        exp_zero.push_back(1'b0);
    endfunction

    function void check_result(logic [55:0] data, logic zflag);
        logic [16:0] ex, ey, ez;
        logic        ez0;
        if (exp_x.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: tdata=%h tuser=%b", data, zflag);
            return;
        end
        ex = exp_x.pop_front();
        ey = exp_y.pop_front();
        ez = exp_z.pop_front();
        ez0 = exp_zero.pop_front();
        checked++;
        if (ez0) zero_seen++;
        if (data[16:0] !== ex || data[33:17] !== ey || data[50:34] !== ez
                || data[55:51] !== 5'd0 || zflag !== ez0) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch #%0d: exp x=%0d y=%0d z=%0d zq=%b, ",
                          "got x=%0d y=%0d z=%0d zq=%b pad=%h"},
                         checked, $signed(ex), $signed(ey), $signed(ez), ez0,
                         $signed(data[16:0]), $signed(data[33:17]), $signed(data[50:34]),
                         zflag, data[55:51]);
        end
    endfunction

    function int pending();
        return exp_x.size();
    endfunction
endclass

module testbench;

    localparam int RANDOM_WORDS = 1550;
    localparam int LATENCY      = 23;
    localparam int IDLE_LIMIT   = 5000;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [qvr_pkg::AXIS_IN_W-1:0]  s_axis_tdata = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [qvr_pkg::AXIS_OUT_W-1:0] m_axis_tdata;
    logic                           m_axis_tuser;

    rotation_scoreboard board = new();
    int  sent = 0;
    int  idle_cycles = 0;
    bit  timed_out = 0;
    bit  hold_off = 0;

    quaternion_vector_rotation_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    // scoreboard updates on accepted words, sampled at the edge
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) board.note_input(s_axis_tdata);
        if (aresetn && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge aclk) begin
        if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold-off
    initial begin : receiver
        int mode;
        int run;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (200) @(posedge aclk);
                hold_off = 0;
            end
            mode = $urandom_range(0, 3);
            run = $urandom_range(1, 40);
            repeat (run) begin
                if (hold_off) break;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2: m_axis_tready <= ($urandom_range(0, 1) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 15) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // offer one word and hold it until accepted
    task automatic send_word(logic [qvr_pkg::AXIS_IN_W-1:0] word);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sent++;
    endtask

    task automatic send_quat(logic [15:0] w, x, y, z, vx, vy, vz);
        send_word({vz, vy, vx, z, y, x, w});
    endtask

    initial begin : stimulus
        int burst;
        int gap;
        int waited;
        logic [qvr_pkg::AXIS_IN_W-1:0] word;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // identity, zero quaternion, extremes, half-way rounding cases
        send_quat(16'h4000, 0, 0, 0, 16'h7fff, 16'h8000, 16'h0001);
        send_quat(0, 0, 0, 0, 16'h1234, 16'h8000, 16'h7fff);
        send_quat(0, 0, 0, 0, 0, 0, 0);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h8000, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000);
        send_quat(0, 16'h4000, 0, 0, 16'h7fff, 16'h8000, 16'h1111);
        send_quat(0, 0, 16'h4000, 0, 16'h7fff, 16'h8000, 16'h1111);
        send_quat(0, 0, 0, 16'h4000, 16'h7fff, 16'h8000, 16'h1111);
        send_quat(16'h2d41, 0, 0, 16'h2d41, 16'h7fff, 16'h8000, 16'h7fff);
        send_quat(1, 1, 0, 0, 1, 1, 1);
        send_quat(1, 1, 1, 0, 1, 0, 0);
        send_quat(16'hffff, 1, 1, 1, 16'h0003, 16'hfffd, 16'h0005);
        send_quat(0, 0, 0, 1, 16'h7fff, 16'h7fff, 16'h8000);
        send_quat(3, 0, 0, 1, 5, 16'hfffb, 7);
        send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);

        // long receiver hold-off while the sender keeps offering words
        hold_off = 1;
        repeat (60)
            send_word(qvr_pkg::AXIS_IN_W'({$urandom, $urandom, $urandom, $urandom}));

        while (sent < RANDOM_WORDS + 16 + 60) begin
            burst = $urandom_range(1, 50);
            repeat (burst) begin
                if ($urandom_range(0, 19) == 0)
                    word = qvr_pkg::AXIS_IN_W'({$urandom, $urandom, $urandom, $urandom})
                         & {{48{1'b1}}, 64'h0};
                else
                    word = {rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                            rand_comp(), rand_comp(), rand_comp()};
                send_word(word);
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (board.pending() > 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge aclk);

        $display("sent %0d words, checked %0d results, %0d with zero quaternion",
                 sent, board.checked, board.zero_seen);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("mismatches: %0d, results missing: %0d", board.mismatches, board.pending());
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
